### design/cbm_pkg.sv
package cbm_pkg;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	localparam logic [2:0] ROUTE_DATA      = 3'd0;
	localparam logic [2:0] ROUTE_ROM_READ  = 3'd1;
	localparam logic [2:0] ROUTE_RAM_READ  = 3'd2;
	localparam logic [2:0] ROUTE_RAM_WRITE = 3'd3;
	localparam logic [2:0] ROUTE_NONE      = 3'd4;

	localparam logic [1:0] CFG_ROM_BANK_MASK = 2'd0;
	localparam logic [1:0] CFG_RAM_BANK_MASK = 2'd1;
	localparam logic [1:0] CFG_RAM_PRESENT   = 2'd2;
	localparam logic [1:0] CFG_CYCLES_PER_S  = 2'd3;

	localparam logic [7:0] RTC_SEC  = 8'h08;
	localparam logic [7:0] RTC_MIN  = 8'h09;
	localparam logic [7:0] RTC_HRS  = 8'h0A;
	localparam logic [7:0] RTC_DAYS = 8'h0B;
	localparam logic [7:0] RTC_CTRL = 8'h0C;

	localparam logic [6:0]  ROM_MASK_RST = 7'd127;
	localparam logic [1:0]  RAM_MASK_RST = 2'd3;
	localparam logic [23:0] CPS_RST      = 24'd4213440;

	localparam logic [7:0] OPEN_BUS   = 8'hFF;
	localparam logic [7:0] CTRL_WMASK = 8'hC1;

	localparam int CFG_DATA_W = 24;
	localparam int ACCUM_W    = 25;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [15:0] tick_cycles;
	} in_t;

	typedef struct packed {
		logic [2:0]  route;
		logic [20:0] mem_address;
		logic [7:0]  read_data;
		logic [7:0]  ram_write_data;
		logic        access_invalid;
	} out_t;

endpackage

### design/cartridge_bank_mapper_rtc.sv
// Cartridge bank controller with real-time clock.
// Input channel (in_valid/in_ready/in_data) carries bus reads, bus writes and
// tick items; each one yields exactly one result on the output channel
// (out_valid/out_ready/out_data): a physical ROM/RAM byte address, RTC data
// or open-bus 0xFF, or a "none" route for control writes and ticks.
// Each item first sits in the input register; then the decode, bank-register
// update and real-time clock step feed the result register.
// Throughput is one item per cycle while the receiver takes results; every
// state update (bank registers, cycle accumulator, seconds..days cascade) is
// made as the item moves on, so the next item sees it with no bubble.
// When the receiver stalls, the result register holds and the stall ripples
// back to the input register and then to in_ready; the block still takes one
// more item while a result waits.
// Reset clears the bank state, clock counters and latched time, and restores
// the register defaults (ROM mask 127, RAM mask 3, RAM present, 4213440
// cycles per second). The user writes configuration through cfg_we, cfg_index
// and cfg_data only with no item in flight; the block does not enforce it.
module cartridge_bank_mapper_rtc (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  cbm_pkg::in_t                       in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output cbm_pkg::out_t                      out_data,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [cbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// configuration
	logic [6:0]  rom_mask_q;
	logic [1:0]  ram_mask_q;
	logic        ram_present_q;
	logic [23:0] cps_q;

	// controller state
	logic        ram_enabled_q;
	logic        latch_armed_q;
	logic [6:0]  rom_bank_q;
	logic [7:0]  bank_sel_q;
	logic [cbm_pkg::ACCUM_W-1:0] accum_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hrs_q;
	logic [7:0]  days_q;
	logic [7:0]  ctrl_q;
	logic [7:0]  latched_q [5];

	// pipeline
	logic          valid_s1;
	cbm_pkg::in_t  item_s1;
	logic          out_valid_q;
	cbm_pkg::out_t out_q;

	logic advance;
	logic fire_s1;

	// next-state values
	logic        ram_enabled_d;
	logic        latch_armed_d;
	logic [6:0]  rom_bank_d;
	logic [7:0]  bank_sel_d;
	logic [cbm_pkg::ACCUM_W-1:0] accum_d;
	logic [5:0]  sec_d;
	logic [5:0]  min_d;
	logic [4:0]  hrs_d;
	logic [7:0]  days_d;
	logic [7:0]  ctrl_d;
	logic        do_latch;
	cbm_pkg::out_t res;

	logic        sel_ram;
	logic        sel_rtc;
	logic [7:0]  rtc_rd;
	logic [20:0] ram_addr;
	logic [cbm_pkg::ACCUM_W-1:0] accum_sum;
	logic        sec_due;
	logic [8:0]  days9;

	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign fire_s1   = valid_s1 && advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sel_ram = ram_enabled_q && ram_present_q && (bank_sel_q <= 8'h03);
	assign sel_rtc = ram_enabled_q && (bank_sel_q >= cbm_pkg::RTC_SEC)
		&& (bank_sel_q <= cbm_pkg::RTC_CTRL);
	assign ram_addr = {6'd0, bank_sel_q[1:0] & ram_mask_q, item_s1.address[12:0]};
	assign accum_sum = accum_q + {{(cbm_pkg::ACCUM_W-16){1'b0}}, item_s1.tick_cycles};
	assign sec_due = accum_sum >= {1'b0, cps_q};
	assign days9 = {ctrl_q[0], days_q};

	always_comb begin
		unique case (bank_sel_q)
			cbm_pkg::RTC_SEC:  rtc_rd = latched_q[0];
			cbm_pkg::RTC_MIN:  rtc_rd = latched_q[1];
			cbm_pkg::RTC_HRS:  rtc_rd = latched_q[2];
			cbm_pkg::RTC_DAYS: rtc_rd = latched_q[3];
			default:           rtc_rd = latched_q[4];
		endcase
	end

	always_comb begin
		ram_enabled_d = ram_enabled_q;
		latch_armed_d = latch_armed_q;
		rom_bank_d    = rom_bank_q;
		bank_sel_d    = bank_sel_q;
		accum_d       = accum_q;
		sec_d         = sec_q;
		min_d         = min_q;
		hrs_d         = hrs_q;
		days_d        = days_q;
		ctrl_d        = ctrl_q;
		do_latch      = 1'b0;
		res           = '0;
		res.route     = cbm_pkg::ROUTE_NONE;

		unique case (item_s1.kind)
			cbm_pkg::KIND_READ: begin
				if (!item_s1.address[15] && !item_s1.address[14]) begin
					res.route       = cbm_pkg::ROUTE_ROM_READ;
					res.mem_address = {7'd0, item_s1.address[13:0]};
				end else if (!item_s1.address[15]) begin
					res.route       = cbm_pkg::ROUTE_ROM_READ;
					res.mem_address = {rom_bank_q & rom_mask_q, item_s1.address[13:0]};
				end else if (item_s1.address[15:13] == 3'b101 && sel_ram) begin
					res.route       = cbm_pkg::ROUTE_RAM_READ;
					res.mem_address = ram_addr;
				end else if (item_s1.address[15:13] == 3'b101 && sel_rtc) begin
					res.route     = cbm_pkg::ROUTE_DATA;
					res.read_data = rtc_rd;
				end else begin
					res.route          = cbm_pkg::ROUTE_DATA;
					res.read_data      = cbm_pkg::OPEN_BUS;
					res.access_invalid = 1'b1;
				end
			end
			cbm_pkg::KIND_WRITE: begin
				unique case (item_s1.address[15:13])
					3'b000: ram_enabled_d = (item_s1.write_data[3:0] == 4'hA);
					3'b001: rom_bank_d = (item_s1.write_data[6:0] == 7'd0) ? 7'd1
						: item_s1.write_data[6:0];
					3'b010: bank_sel_d = item_s1.write_data;
					3'b011: begin
						if (item_s1.write_data == 8'd0) begin
							latch_armed_d = 1'b1;
						end else begin
							do_latch      = (item_s1.write_data == 8'd1) && latch_armed_q;
							latch_armed_d = 1'b0;
						end
					end
					3'b101: begin
						if (sel_ram) begin
							res.route          = cbm_pkg::ROUTE_RAM_WRITE;
							res.mem_address    = ram_addr;
							res.ram_write_data = item_s1.write_data;
						end else if (sel_rtc) begin
							unique case (bank_sel_q)
								cbm_pkg::RTC_SEC: begin
									sec_d   = item_s1.write_data[5:0];
									accum_d = '0;
								end
								cbm_pkg::RTC_MIN:  min_d  = item_s1.write_data[5:0];
								cbm_pkg::RTC_HRS:  hrs_d  = item_s1.write_data[4:0];
								cbm_pkg::RTC_DAYS: days_d = item_s1.write_data;
								default: ctrl_d = item_s1.write_data & cbm_pkg::CTRL_WMASK;
							endcase
						end else begin
							res.access_invalid = 1'b1;
						end
					end
					default: res.access_invalid = 1'b1;
				endcase
			end
			cbm_pkg::KIND_TICK: begin
				if (!ctrl_q[6]) begin
					accum_d = accum_sum;
					if (sec_due) begin
						accum_d = accum_sum - {1'b0, cps_q};
						// one-second cascade; out-of-range fields just wrap
						if (sec_q != 6'd59) begin
							sec_d = sec_q + 6'd1;
						end else begin
							sec_d = '0;
							if (min_q != 6'd59) begin
								min_d = min_q + 6'd1;
							end else begin
								min_d = '0;
								if (hrs_q != 5'd23) begin
									hrs_d = hrs_q + 5'd1;
								end else begin
									hrs_d = '0;
									if (days9 == 9'd511) begin
										days_d = '0;
										ctrl_d = {1'b1, ctrl_q[6:1], 1'b0};
									end else begin
										// carry into day bit 8, keep it once set
										days_d = days_q + 8'd1;
										ctrl_d = {ctrl_q[7:1], ctrl_q[0] | (days_q == 8'hFF)};
									end
								end
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_mask_q    <= cbm_pkg::ROM_MASK_RST;
			ram_mask_q    <= cbm_pkg::RAM_MASK_RST;
			ram_present_q <= 1'b1;
			cps_q         <= cbm_pkg::CPS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbm_pkg::CFG_ROM_BANK_MASK: rom_mask_q    <= cfg_data[6:0];
				cbm_pkg::CFG_RAM_BANK_MASK: ram_mask_q    <= cfg_data[1:0];
				cbm_pkg::CFG_RAM_PRESENT:   ram_present_q <= cfg_data[0];
				default:                    cps_q         <= cfg_data[23:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enabled_q <= 1'b0;
			latch_armed_q <= 1'b0;
			rom_bank_q    <= 7'd1;
			bank_sel_q    <= '0;
			accum_q       <= '0;
			sec_q         <= '0;
			min_q         <= '0;
			hrs_q         <= '0;
			days_q        <= '0;
			ctrl_q        <= '0;
			for (int i = 0; i < 5; i++) begin
				latched_q[i] <= '0;
			end
		end else if (fire_s1) begin
			ram_enabled_q <= ram_enabled_d;
			latch_armed_q <= latch_armed_d;
			rom_bank_q    <= rom_bank_d;
			bank_sel_q    <= bank_sel_d;
			accum_q       <= accum_d;
			sec_q         <= sec_d;
			min_q         <= min_d;
			hrs_q         <= hrs_d;
			days_q        <= days_d;
			ctrl_q        <= ctrl_d;
			if (do_latch) begin
				latched_q[0] <= {2'd0, sec_q};
				latched_q[1] <= {2'd0, min_q};
				latched_q[2] <= {3'd0, hrs_q};
				latched_q[3] <= days_q;
				latched_q[4] <= ctrl_q;
			end
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// payload: hold while stalled
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (fire_s1) begin
			out_q <= res;
		end
	end

endmodule
